>>> rtl/assert_macros.svh
// Assertion helpers shared by vgm_front and vgm_engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/vgm_pkg.sv
package vgm_pkg;
    localparam int EDGE_CELLS_DEF = 16;
    localparam int ID_BITS_DEF = 8;
    localparam int CRD_W = 4;
    localparam int IN_W = 24;
    localparam int OUT_W = 64;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_START = 2'd1,
        ACT_FETCH = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Command handed from the front end to the engine through the queue.
    typedef struct packed {
        action_t     act;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [3:0]  z;
        logic [7:0]  id;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_SCAN,
        ST_RUN,
        ST_ROWCHK,
        ST_ROWMARK,
        ST_EMIT,
        ST_DONE
    } eng_state_t;

    function automatic logic [3:0] bright(input logic [2:0] dir);
        logic [3:0] b;
        begin
            case (dir)
                3'd0: b = 4'd13;
                3'd1: b = 4'd14;
                3'd2: b = 4'd11;
                3'd3: b = 4'd15;
                3'd4: b = 4'd12;
                3'd5: b = 4'd14;
                default: b = 4'd0;
            endcase
            return b;
        end
    endfunction

    // Vertex table: {add height, add width, u code[1:0], v code[1:0]}.
    function automatic logic [5:0] vtx(input logic [2:0] dir, input logic [1:0] k);
        logic [5:0] e;
        begin
            case ({dir, k})
                5'b000_00: e = 6'b1_1_01_00;
                5'b000_01: e = 6'b1_0_00_00;
                5'b000_10: e = 6'b0_1_01_10;
                5'b000_11: e = 6'b0_0_00_10;
                5'b001_00: e = 6'b1_1_00_00;
                5'b001_01: e = 6'b0_1_00_10;
                5'b001_10: e = 6'b1_0_01_00;
                5'b001_11: e = 6'b0_0_01_10;
                5'b010_00: e = 6'b1_1_01_00;
                5'b010_01: e = 6'b0_1_00_00;
                5'b010_10: e = 6'b1_0_01_10;
                5'b010_11: e = 6'b0_0_00_10;
                5'b011_00: e = 6'b1_1_10_01;
                5'b011_01: e = 6'b1_0_10_00;
                5'b011_10: e = 6'b0_1_00_01;
                5'b011_11: e = 6'b0_0_00_00;
                5'b100_00: e = 6'b1_1_00_00;
                5'b100_01: e = 6'b1_0_00_01;
                5'b100_10: e = 6'b0_1_10_00;
                5'b100_11: e = 6'b0_0_10_01;
                5'b101_00: e = 6'b1_1_10_00;
                5'b101_01: e = 6'b0_1_00_00;
                5'b101_10: e = 6'b1_0_10_01;
                5'b101_11: e = 6'b0_0_00_01;
                default:   e = 6'b0;
            endcase
            return e;
        end
    endfunction
endpackage

>>> rtl/vgm_front.sv
// Front end: classifies items and queues the ones that need work.
`include "assert_macros.svh"
module vgm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,
    output logic                q_valid,
    input  logic                q_pop,
    output vgm_pkg::cmd_t       q_cmd
);
    import vgm_pkg::*;

    localparam int DEPTH = 2;

    cmd_t        mem_reg [DEPTH];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    cmd_t        in_cmd;
    logic        push;

    always_comb
    begin
        in_cmd.act = action_t'(s_tdata[1:0]);
        in_cmd.x   = s_tdata[5:2];
        in_cmd.y   = s_tdata[9:6];
        in_cmd.z   = s_tdata[13:10];
        in_cmd.id  = s_tdata[21:14];
    end

    assign s_tready = (cnt_reg != 2'(DEPTH));
    // Unknown actions are consumed here and never reach the engine.
    assign push = s_tvalid && s_tready && (in_cmd.act != ACT_NONE);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd = mem_reg[rp_reg];

    always_comb
    begin
        wp_next = push ? ~wp_reg : wp_reg;
        rp_next = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && !q_valid, "pop from empty queue")
    `ASSERT_CLK(a_cnt_range, clk, rst_n, cnt_reg <= 2'(DEPTH), "queue count out of range")
    `ASSERT_CLK(a_cnt_step, clk, rst_n,
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1, "queue count step")
endmodule

>>> rtl/vgm_engine.sv
// Back end: voxel store, covered mask and the greedy scan.
`include "assert_macros.svh"
module vgm_engine #(
    parameter int EDGE_CELLS = vgm_pkg::EDGE_CELLS_DEF,
    parameter int ID_BITS    = vgm_pkg::ID_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  vgm_pkg::cmd_t       q_cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,
    output logic [1:0]          m_tuser
);
    import vgm_pkg::*;

    localparam int NVOX = 4096;
    localparam logic [2:0] NDIR = 3'd6;
    localparam logic [4:0] E = 5'(EDGE_CELLS);

    // The store has a single read port, so a face probe reads the cell and then
    // its neighbour over two reads.
    logic [ID_BITS-1:0] store [NVOX];
    logic [255:0]       cov_reg;

    eng_state_t st_reg, st_next;
    logic [2:0]  dir_reg, dir_next;
    logic [3:0]  s_reg, s_next;
    logic [3:0]  cpr_reg, cpr_next, cpc_reg, cpc_next;
    logic [11:0] clr_reg, clr_next;
    logic [13:0] qc_reg, qc_next;
    logic [3:0]  r_reg, r_next, c_reg, c_next;
    logic [4:0]  w_reg, w_next, h_reg, h_next;
    logic [3:0]  rr_reg, rr_next, cc_reg, cc_next;
    logic [7:0]  id_reg, id_next;
    logic [1:0]  k_reg, k_next;
    logic        ph_reg, ph_next;
    logic [ID_BITS-1:0] a_reg, a_next;
    logic [ID_BITS-1:0] rd_reg;

    logic [2:0]  dir;
    logic [1:0]  axis;
    logic        side;
    logic [3:0]  s;
    logic [3:0]  qr, qc;
    logic [4:0]  px, py, pz;
    logic        outside;
    logic [11:0] raddr;
    logic        rd_en;
    logic        wr_en;
    logic [11:0] waddr;
    logic [7:0]  fid;
    logic        fmatch;

    assign dir = dir_reg;
    assign axis = dir[2:1];
    assign side = dir[0];
    assign s = s_reg;

    // Cell under test: scan uses pointer, runs use rr/cc.
    always_comb
    begin
        qr = (st_reg == ST_SCAN) ? cpr_reg : rr_reg;
        qc = (st_reg == ST_SCAN) ? cpc_reg : cc_reg;
        px = (axis == 2'd0) ? {1'b0, s} : {1'b0, qr};
        py = (axis == 2'd0) ? {1'b0, qr} : (axis == 2'd1) ? {1'b0, s} : {1'b0, qc};
        pz = (axis == 2'd2) ? {1'b0, s} : {1'b0, qc};
        if (ph_reg)
        begin
            if (axis == 2'd0) px = side ? px + 5'd1 : px - 5'd1;
            else if (axis == 2'd1) py = side ? py + 5'd1 : py - 5'd1;
            else pz = side ? pz + 5'd1 : pz - 5'd1;
        end
        outside = (px >= E) || (py >= E) || (pz >= E);
        raddr = {pz[3:0], py[3:0], px[3:0]};
    end

    logic front_cmd;
    assign front_cmd = (st_reg == ST_IDLE) && q_valid;
    assign wr_en = front_cmd && (q_cmd.act == ACT_WRITE) && (q_cmd.x < E[3:0] || E == 5'd16)
                   && (q_cmd.y < 4'(EDGE_CELLS) || E == 5'd16)
                   && (q_cmd.z < 4'(EDGE_CELLS) || E == 5'd16);
    assign waddr = {q_cmd.z, q_cmd.y, q_cmd.x};
    assign rd_en = 1'b1;

    // After reset every entry is written with zero before any item is taken.
    logic               clr_on;
    logic               mem_we;
    logic [11:0]        mem_wa;
    logic [ID_BITS-1:0] mem_wd;
    assign clr_on = (st_reg == ST_CLR);
    assign mem_we = clr_on || wr_en;
    assign mem_wa = clr_on ? clr_reg : waddr;
    assign mem_wd = clr_on ? '0 : q_cmd.id[ID_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_reg <= store[raddr];
        end
    end

    logic rout_reg;
    logic [ID_BITS-1:0] rval;
    assign rval = rout_reg ? '0 : rd_reg;

    // Face id once the neighbour has been read: a is the cell, rval the neighbour.
    assign fid = (a_reg != '0 && rval == '0) ? 8'(a_reg) : 8'd0;
    logic [7:0] cov_idx;
    assign cov_idx = {rr_reg, cc_reg};
    assign fmatch = (fid == id_reg) && !cov_reg[cov_idx];

    // Each probe takes: address cell (ph=0), read, address neighbour (ph=1), read.
    logic [1:0] sub_reg, sub_next;
    logic       probe_done;
    assign probe_done = (sub_reg == 2'd3);

    logic [15:0] vpos, vattr, vcol;
    logic [5:0]  e;
    logic [4:0]  pr, pcc;
    logic [4:0]  ux, uv;
    logic [4:0]  scx;
    logic [4:0]  vx, vy, vz;

    always_comb
    begin
        e = vtx(dir, k_reg);
        pr = {1'b0, r_reg} + (e[5] ? h_reg : 5'd0);
        pcc = {1'b0, c_reg} + (e[4] ? w_reg : 5'd0);
        ux = (e[3:2] == 2'd1) ? w_reg : (e[3:2] == 2'd2) ? h_reg : 5'd0;
        uv = (e[1:0] == 2'd1) ? w_reg : (e[1:0] == 2'd2) ? h_reg : 5'd0;
        scx = {1'b0, s} + {4'd0, side};
        vx = (axis == 2'd0) ? scx : pr;
        vy = (axis == 2'd0) ? pr : (axis == 2'd1) ? scx : pcc;
        vz = (axis == 2'd2) ? scx : pcc;
        vpos = {1'b0, vx, vy, vz};
        vattr = {id_reg[5:0], ux, uv};
        vcol = {bright(dir), bright(dir), bright(dir), 4'hF};
    end

    logic        o_valid_reg, o_valid_next;
    logic [63:0] o_data_reg, o_data_next;
    logic [1:0]  o_user_reg, o_user_next;
    logic        o_free;
    assign o_free = !o_valid_reg || m_tready;
    assign m_tvalid = o_valid_reg;
    assign m_tdata = o_data_reg;
    assign m_tuser = o_user_reg;

    logic       cov_clr;
    logic       cov_set;
    logic [7:0] cov_set_idx;
    logic       last_cell;
    logic       cpc_wrap, s_wrap;
    logic [3:0] cpr_inc, cpc_inc, s_inc;
    logic [2:0] dir_inc;

    // Next cell of the slice in row order, and the next slice.
    always_comb
    begin
        cpc_wrap = ({1'b0, cpc_reg} + 5'd1 == E);
        cpc_inc = cpc_wrap ? 4'd0 : cpc_reg + 4'd1;
        cpr_inc = cpc_wrap ? cpr_reg + 4'd1 : cpr_reg;
        last_cell = cpc_wrap && ({1'b0, cpr_reg} + 5'd1 == E);
        s_wrap = ({1'b0, s_reg} + 5'd1 == E);
        s_inc = s_wrap ? 4'd0 : s_reg + 4'd1;
        dir_inc = s_wrap ? dir_reg + 3'd1 : dir_reg;
    end

    always_comb
    begin
        st_next = st_reg;
        dir_next = dir_reg;
        s_next = s_reg;
        cpr_next = cpr_reg;
        cpc_next = cpc_reg;
        clr_next = clr_reg;
        qc_next = qc_reg;
        r_next = r_reg;
        c_next = c_reg;
        w_next = w_reg;
        h_next = h_reg;
        rr_next = rr_reg;
        cc_next = cc_reg;
        id_next = id_reg;
        k_next = k_reg;
        ph_next = ph_reg;
        a_next = a_reg;
        sub_next = sub_reg;
        cov_clr = 1'b0;
        cov_set = 1'b0;
        cov_set_idx = {rr_reg, cc_reg};
        q_pop = 1'b0;
        unique case (st_reg)
            ST_CLR:
            begin
                clr_next = clr_reg + 12'd1;
                if (clr_reg == 12'(NVOX - 1))
                begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = (q_cmd.act != ACT_FETCH);
                    if (q_cmd.act == ACT_START)
                    begin
                        dir_next = '0;
                        s_next = '0;
                        cpr_next = '0;
                        cpc_next = '0;
                        qc_next = '0;
                        cov_clr = 1'b1;
                    end
                    else if (q_cmd.act == ACT_FETCH)
                    begin
                        q_pop = 1'b1;
                        sub_next = 2'd0;
                        ph_next = 1'b0;
                        st_next = (dir_reg < NDIR) ? ST_SCAN : ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                rr_next = cpr_reg;
                cc_next = cpc_reg;
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd1)
                begin
                    ph_next = 1'b1;
                end
                if (sub_reg == 2'd2)
                begin
                    a_next = rval;
                end
                if (probe_done)
                begin
                    ph_next = 1'b0;
                    if (fid != 8'd0 && !cov_reg[{rr_reg, cc_reg}])
                    begin
                        id_next = fid;
                        r_next = rr_reg;
                        c_next = cc_reg;
                        w_next = 5'd0;
                        h_next = 5'd1;
                        st_next = ST_RUN;
                    end
                    else if (last_cell)
                    begin
                        dir_next = dir_inc;
                        s_next = s_inc;
                        cpr_next = '0;
                        cpc_next = '0;
                        cov_clr = 1'b1;
                        st_next = (dir_inc < NDIR) ? ST_SCAN : ST_DONE;
                    end
                    else
                    begin
                        cpr_next = cpr_inc;
                        cpc_next = cpc_inc;
                    end
                end
            end
            ST_RUN:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd1) ph_next = 1'b1;
                if (sub_reg == 2'd2) a_next = rval;
                if (probe_done)
                begin
                    ph_next = 1'b0;
                    if (fmatch)
                    begin
                        cov_set = 1'b1;
                        w_next = w_reg + 5'd1;
                        if ({1'b0, cc_reg} + 5'd1 < E)
                        begin
                            cc_next = cc_reg + 4'd1;
                        end
                        else
                        begin
                            rr_next = r_reg + 4'd1;
                            cc_next = c_reg;
                            st_next = ({1'b0, r_reg} + 5'd1 < E) ? ST_ROWCHK : ST_EMIT;
                        end
                    end
                    else
                    begin
                        rr_next = r_reg + 4'd1;
                        cc_next = c_reg;
                        st_next = ({1'b0, r_reg} + 5'd1 < E) ? ST_ROWCHK : ST_EMIT;
                    end
                    if (st_next == ST_EMIT)
                    begin
                        k_next = 2'd0;
                    end
                end
            end
            ST_ROWCHK:
            begin
                sub_next = sub_reg + 2'd1;
                if (sub_reg == 2'd1) ph_next = 1'b1;
                if (sub_reg == 2'd2) a_next = rval;
                if (probe_done)
                begin
                    ph_next = 1'b0;
                    if (!fmatch)
                    begin
                        k_next = 2'd0;
                        st_next = ST_EMIT;
                    end
                    else if ({1'b0, cc_reg} + 5'd1 == {1'b0, c_reg} + w_reg)
                    begin
                        cc_next = c_reg;
                        st_next = ST_ROWMARK;
                    end
                    else
                    begin
                        cc_next = cc_reg + 4'd1;
                    end
                end
            end
            ST_ROWMARK:
            begin
                cov_set = 1'b1;
                if ({1'b0, cc_reg} + 5'd1 == {1'b0, c_reg} + w_reg)
                begin
                    h_next = h_reg + 5'd1;
                    cc_next = c_reg;
                    rr_next = rr_reg + 4'd1;
                    sub_next = 2'd0;
                    if ({1'b0, rr_reg} + 5'd1 < E)
                    begin
                        st_next = ST_ROWCHK;
                    end
                    else
                    begin
                        k_next = 2'd0;
                        st_next = ST_EMIT;
                    end
                end
                else
                begin
                    cc_next = cc_reg + 4'd1;
                end
            end
            ST_EMIT:
            begin
                if (o_free)
                begin
                    k_next = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        qc_next = qc_reg + 14'd1;
                        if (last_cell)
                        begin
                            dir_next = dir_inc;
                            s_next = s_inc;
                            cpr_next = '0;
                            cpc_next = '0;
                            cov_clr = 1'b1;
                        end
                        else
                        begin
                            cpr_next = cpr_inc;
                            cpc_next = cpc_inc;
                        end
                        st_next = ST_IDLE;
                    end
                end
            end
            ST_DONE:
            begin
                if (o_free)
                begin
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        o_valid_next = o_valid_reg && !m_tready;
        o_data_next = o_data_reg;
        o_user_next = o_user_reg;
        if (st_reg == ST_EMIT && o_free)
        begin
            o_valid_next = 1'b1;
            o_data_next = {qc_reg, 2'b00, vcol, vattr, vpos};
            o_user_next = {1'b0, k_reg == 2'd3};
        end
        else if (st_reg == ST_DONE && o_free)
        begin
            o_valid_next = 1'b1;
            o_data_next = '0;
            o_user_next = 2'b10;
        end
    end

    always_ff @(posedge clk)
    begin
        o_data_reg <= o_data_next;
        o_user_reg <= o_user_next;
        r_reg <= r_next;
        c_reg <= c_next;
        w_reg <= w_next;
        h_reg <= h_next;
        rr_reg <= rr_next;
        cc_reg <= cc_next;
        id_reg <= id_next;
        k_reg <= k_next;
        a_reg <= a_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_CLR;
            dir_reg <= '0;
            s_reg <= '0;
            cpr_reg <= '0;
            cpc_reg <= '0;
            clr_reg <= '0;
            qc_reg <= '0;
            ph_reg <= 1'b0;
            sub_reg <= 2'd0;
            o_valid_reg <= 1'b0;
            cov_reg <= '0;
            rout_reg <= 1'b1;
        end
        else
        begin
            st_reg <= st_next;
            dir_reg <= dir_next;
            s_reg <= s_next;
            cpr_reg <= cpr_next;
            cpc_reg <= cpc_next;
            clr_reg <= clr_next;
            qc_reg <= qc_next;
            ph_reg <= ph_next;
            sub_reg <= sub_next;
            o_valid_reg <= o_valid_next;
            rout_reg <= outside;
            if (cov_clr)
            begin
                cov_reg <= '0;
            end
            else if (cov_set)
            begin
                cov_reg[cov_set_idx] <= 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_out_hold, clk, rst_n,
        m_tvalid && !m_tready && (st_reg == ST_EMIT || st_reg == ST_DONE) && o_free,
        "output overwritten while stalled")
    `ASSERT_CLK(a_done_zero, clk, rst_n, (m_tvalid && m_tuser[1]) |-> m_tdata == 64'd0,
        "done result carries data")
    `ASSERT_CLK(a_emit_from, clk, rst_n,
        $rose(st_reg == ST_EMIT) |-> (w_reg != 5'd0 && h_reg != 5'd0), "empty quad emitted")
endmodule

>>> rtl/voxel_greedy_mesher.sv
// Greedy mesher for a voxel cube. Write items fill the 4096-entry store; a start item
// restarts the scan; each fetch item yields four vertex transfers of the next merged face
// rectangle, or one done transfer. After reset the store is cleared in a pass over all
// 4096 entries, during which up to two items wait in the input queue. A fetch leaves the
// queue, then probes cells through the single-port store read (cell, then its neighbor),
// marks each cell when a row is added, and sends each vertex while the output is ready.
module voxel_greedy_mesher #(
    parameter int EDGE_CELLS = vgm_pkg::EDGE_CELLS_DEF,
    parameter int ID_BITS    = vgm_pkg::ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[1:0], cell_x[5:2], cell_y[9:6], cell_z[13:10], block_id[21:14], zero fill
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // position_word[15:0], attribute_word[31:16], colour_word[47:32], base_index[63:48]
    output logic [63:0] m_axis_tdata,
    // last_vertex[0], done_res[1]
    output logic [1:0]  m_axis_tuser
);
    import vgm_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    vgm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
    );

    vgm_engine #(.EDGE_CELLS(EDGE_CELLS), .ID_BITS(ID_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_tdata(m_axis_tdata), .m_tuser(m_axis_tuser)
    );
endmodule

>>> test/tb_voxel_greedy_mesher.sv
`timescale 1ns / 1ps

module tb_voxel_greedy_mesher;
    import vgm_pkg::*;

    localparam int EDGE = 16;
    localparam int AREA = EDGE * EDGE;
    localparam int SLICES = 6 * EDGE;

    // Per direction and vertex: add height to row, add width to column, u code, v code
    // (0 zero, 1 width, 2 height).
    localparam int CORNER_TAB [6][4][4] = '{
        '{'{1,1,1,0}, '{1,0,0,0}, '{0,1,1,2}, '{0,0,0,2}},
        '{'{1,1,0,0}, '{0,1,0,2}, '{1,0,1,0}, '{0,0,1,2}},
        '{'{1,1,1,0}, '{0,1,0,0}, '{1,0,1,2}, '{0,0,0,2}},
        '{'{1,1,2,1}, '{1,0,2,0}, '{0,1,0,1}, '{0,0,0,0}},
        '{'{1,1,0,0}, '{1,0,0,1}, '{0,1,2,0}, '{0,0,2,1}},
        '{'{1,1,2,0}, '{0,1,0,0}, '{1,0,2,1}, '{0,0,0,1}}
    };
    localparam int SHADE_TAB [6] = '{13, 14, 11, 15, 12, 14};

    typedef struct packed {
        logic [15:0] position;
        logic [15:0] attribute;
        logic [15:0] colour;
        logic [15:0] base;
        logic        last;
        logic        done;
    } vertex_t;

    typedef struct {
        action_t    act;
        logic [3:0] x;
        logic [3:0] y;
        logic [3:0] z;
        logic [7:0] id;
        bit         done_row;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    // Mirror of the mesher state.
    logic [7:0]  voxels [4096];
    bit          covered [AREA];
    int          slice_idx;
    int          cell_idx;
    logic [13:0] quad_num;

    vertex_t     vertex_q [$];
    stim_row_t   rows [$];
    int          errors = 0;
    bit          quiet_mode = 1'b0;
    int          ready_stall = 0;

    voxel_greedy_mesher u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (quiet_mode || p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void add_row(input action_t act, input logic [3:0] x,
                                    input logic [3:0] y, input logic [3:0] z,
                                    input logic [7:0] id, input bit done_row);
        stim_row_t row;
        row.act = act;
        row.x = x;
        row.y = y;
        row.z = z;
        row.id = id;
        row.done_row = done_row;
        rows.insert(rows.size(), row);
    endfunction

    function automatic logic [7:0] voxel_at(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0 || x >= EDGE || y >= EDGE || z >= EDGE)
            return 8'd0;
        return voxels[(z << 8) | (y << 4) | x];
    endfunction

    function automatic void slice_to_xyz(int axis, int s, int r, int c,
                                         output int x, output int y, output int z);
        if (axis == 0)
        begin
            x = s; y = r; z = c;
        end
        else if (axis == 1)
        begin
            x = r; y = s; z = c;
        end
        else
        begin
            x = r; y = c; z = s;
        end
    endfunction

    // Id of the exposed face at (row, column) of a slice, zero where there is none.
    function automatic logic [7:0] exposed_id(int axis, int side, int s, int r, int c);
        int x, y, z, d;
        logic [7:0] id;
        slice_to_xyz(axis, s, r, c, x, y, z);
        id = voxel_at(x, y, z);
        d = side ? 1 : -1;
        if (id == 0)
            return 8'd0;
        if (axis == 0)
            x += d;
        else if (axis == 1)
            y += d;
        else
            z += d;
        return (voxel_at(x, y, z) != 0) ? 8'd0 : id;
    endfunction

    function automatic void advance_slice();
        slice_idx = (slice_idx + 1) & 8'h7F;
        cell_idx = 0;
        foreach (covered[i])
            covered[i] = 1'b0;
    endfunction

    // Finds the next merged face rectangle and builds its four vertices, or a done word.
    function automatic int next_quad(output vertex_t res [4]);
        int dir, axis, side, s, r, c, w, h, rr, cc, k, x, y, z, pr, pc, u, v, b;
        logic [7:0] id;
        bit ok;
        while (slice_idx < SLICES)
        begin
            dir = slice_idx / EDGE;
            axis = dir >> 1;
            side = dir & 1;
            s = slice_idx % EDGE;
            for (int ci = cell_idx; ci < AREA; ci++)
            begin
                r = ci / EDGE;
                c = ci % EDGE;
                id = exposed_id(axis, side, s, r, c);
                if (id == 0 || covered[(r << 4) | c])
                    continue;
                w = 0;
                h = 1;
                for (cc = c; cc < EDGE; cc++)
                begin
                    if (covered[(r << 4) | cc] || exposed_id(axis, side, s, r, cc) != id)
                        break;
                    covered[(r << 4) | cc] = 1'b1;
                    w++;
                end
                for (rr = r + 1; rr < EDGE; rr++)
                begin
                    ok = 1'b1;
                    for (cc = c; cc < c + w; cc++)
                        if (covered[(rr << 4) | cc] ||
                            exposed_id(axis, side, s, rr, cc) != id)
                        begin
                            ok = 1'b0;
                            break;
                        end
                    if (!ok)
                        break;
                    for (cc = c; cc < c + w; cc++)
                        covered[(rr << 4) | cc] = 1'b1;
                    h++;
                end
                if (ci + 1 >= AREA)
                    advance_slice();
                else
                    cell_idx = ci + 1;
                b = SHADE_TAB[dir];
                for (k = 0; k < 4; k++)
                begin
                    pr = r + (CORNER_TAB[dir][k][0] ? h : 0);
                    pc = c + (CORNER_TAB[dir][k][1] ? w : 0);
                    u = CORNER_TAB[dir][k][2] == 1 ? w : CORNER_TAB[dir][k][2] == 2 ? h : 0;
                    v = CORNER_TAB[dir][k][3] == 1 ? w : CORNER_TAB[dir][k][3] == 2 ? h : 0;
                    slice_to_xyz(axis, s + side, pr, pc, x, y, z);
                    res[k].position  = 16'((x << 10) | (y << 5) | z);
                    res[k].attribute = 16'((int'(id) << 10) | (u << 5) | v);
                    res[k].colour    = 16'((b << 12) | (b << 8) | (b << 4) | 15);
                    res[k].base      = {quad_num, 2'b00};
                    res[k].last      = (k == 3);
                    res[k].done      = 1'b0;
                end
                quad_num = quad_num + 1'b1;
                return 4;
            end
            advance_slice();
        end
        res[0] = '0;
        res[0].done = 1'b1;
        return 1;
    endfunction

    // Drives one input transfer and updates the mirror once it is accepted.
    task automatic send_item(input action_t act, input logic [3:0] x, input logic [3:0] y,
                             input logic [3:0] z, input logic [7:0] id, input bit done_row,
                             output bit got_done);
        int gap, n;
        vertex_t res [4];
        vertex_t done_word;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, id, z, y, x, act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        got_done = 1'b0;
        case (act)
            ACT_WRITE: voxels[{z, y, x}] = id;
            ACT_START:
            begin
                advance_slice();
                slice_idx = 0;
                quad_num = '0;
            end
            ACT_FETCH:
            begin
                n = next_quad(res);
                got_done = (n == 1);
                if (done_row)
                begin
                    done_word = '0;
                    done_word.done = 1'b1;
                    vertex_q.insert(vertex_q.size(), done_word);
                end
                else
                    for (int k = 0; k < n; k++)
                        vertex_q.insert(vertex_q.size(), res[k]);
            end
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h actual %h", $realtime, name, want, got);
            errors++;
        end
    endtask

    always @(negedge clk)
    begin
        if (ready_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_stall <= ready_stall - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                ready_stall <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (vertex_q.size() == 0)
            begin
                $display("%0t: unexpected transfer, expected none actual %h %h",
                         $realtime, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = vertex_q.pop_front();
                check_field("position_word", want.position, m_axis_tdata[15:0]);
                check_field("attribute_word", want.attribute, m_axis_tdata[31:16]);
                check_field("colour_word", want.colour, m_axis_tdata[47:32]);
                check_field("base_index", want.base, m_axis_tdata[63:48]);
                check_field("last_vertex", 16'(want.last), 16'(m_axis_tuser[0]));
                check_field("done_res", 16'(want.done), 16'(m_axis_tuser[1]));
            end
        end
    end

    initial
    begin
        bit        got_done;
        int        writes;
        logic [3:0] x, y, z;
        logic [7:0] id;

        foreach (voxels[i])
            voxels[i] = 8'd0;
        advance_slice();
        slice_idx = 0;
        quad_num = '0;

        // A 2x2x1 block of the top id at the low corner and a lone cell at the high
        // corner: twelve quads, then done twice.
        add_row(ACT_WRITE, 4'd0, 4'd0, 4'd0, 8'd255, 1'b0);
        add_row(ACT_WRITE, 4'd15, 4'd15, 4'd15, 8'd1, 1'b0);
        add_row(ACT_WRITE, 4'd1, 4'd0, 4'd0, 8'd255, 1'b0);
        add_row(ACT_WRITE, 4'd0, 4'd1, 4'd0, 8'd255, 1'b0);
        add_row(ACT_WRITE, 4'd1, 4'd1, 4'd0, 8'd255, 1'b0);
        add_row(ACT_NONE, 4'd15, 4'd15, 4'd15, 8'd255, 1'b0);
        add_row(ACT_START, 4'd0, 4'd0, 4'd0, 8'd0, 1'b0);
        repeat (12)
            add_row(ACT_FETCH, 4'd0, 4'd0, 4'd0, 8'd0, 1'b0);
        repeat (2)
            add_row(ACT_FETCH, 4'd0, 4'd0, 4'd0, 8'd0, 1'b1);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_item(rows[i].act, rows[i].x, rows[i].y, rows[i].z, rows[i].id,
                      rows[i].done_row, got_done);

        // Each pass fills part of the cube, with unknown actions mixed into the fill, then
        // fetches until done; a few writes land in the middle of the scan.
        for (int pass = 0; pass < 3; pass++)
        begin
            quiet_mode = (pass == 1);
            send_item(ACT_START, 4'd0, 4'd0, 4'd0, 8'd0, 1'b0, got_done);
            writes = $urandom_range(30, 45);
            for (int i = 0; i < writes; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    x = 4'($urandom_range(0, 3));
                    y = 4'($urandom_range(0, 3));
                    z = 4'($urandom_range(0, 3));
                    id = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 2));
                end
                else
                begin
                    x = 4'($urandom_range(0, 15));
                    y = 4'($urandom_range(0, 15));
                    z = 4'($urandom_range(0, 15));
                    id = 8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 19) == 0)
                    send_item(ACT_NONE, x, y, z, id, 1'b0, got_done);
                else
                    send_item(ACT_WRITE, x, y, z, id, 1'b0, got_done);
            end
            got_done = 1'b0;
            while (!got_done)
            begin
                if ($urandom_range(0, 29) == 0)
                    send_item(ACT_WRITE, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), 1'b0,
                              got_done);
                send_item(ACT_FETCH, 4'd0, 4'd0, 4'd0, 8'd0, 1'b0, got_done);
            end
            send_item(ACT_FETCH, 4'd0, 4'd0, 4'd0, 8'd0, 1'b0, got_done);
        end

        s_axis_tvalid <= 1'b0;
        while (vertex_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

>>> voxel_greedy_mesher.f
+incdir+rtl
rtl/vgm_pkg.sv
rtl/vgm_front.sv
rtl/vgm_engine.sv
rtl/voxel_greedy_mesher.sv
test/tb_voxel_greedy_mesher.sv
